>>> src/bdq_pkg.sv
// Package for the bounded deque: sizes, codes, cell control and packing helpers.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH);

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int OUT_W    = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REMOVE     = 3'd4,
        ACT_REVERSE    = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // operation on the physical row (entry 0 at the low end)
    typedef enum logic [2:0] {
        PH_NONE,
        PH_PUSH_LO,
        PH_PUSH_HI,
        PH_POP_LO,
        PH_POP_HI,
        PH_REMOVE,
        PH_REVERSE
    } t_phys_op;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } t_cell_op;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_cell_op op;
        t_word    word;   // word to load, also the search key
    } t_cell_ctl;

    function automatic t_word value_to_word(input logic [VALUE_W-1:0] v);
        logic [WORD_BITS+VALUE_W-1:0] t;
        t = {{WORD_BITS{1'b0}}, v};
        return t[WORD_BITS-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] word_to_out(input t_word w);
        logic [WORD_BITS+OUT_W-1:0] t;
        t = {{OUT_W{1'b0}}, w};
        return t[OUT_W-1:0];
    endfunction

    function automatic logic [OCC_W-1:0] count_to_occ(input logic [CNT_W-1:0] c);
        logic [CNT_W+OCC_W-1:0] t;
        t = {{OCC_W{1'b0}}, c};
        return t[OCC_W-1:0];
    endfunction

endpackage

>>> src/bounded_deque_with_value_remove.sv
// Top level of the bounded deque: control, row of cells, result register.
// Row and count update at the accepting edge, which marks the request pending; the
// result then enters the output register once it is empty or being read, raising o_m_tvalid.
// A new request waits (o_s_tready low) until the pending result has moved to the output
// register; while a result waits at the output, one more request is taken.
// Reset (synchronous, i_rst_n low): queue empty, orientation normal, no result.
// Cell words are not reset; only entries below the count are ever read.
`timescale 1ns / 1ps

module bounded_deque_with_value_remove import bdq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [2:0]  i_s_tuser,   // [2:0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata    // [1:0] status, [6:2] occupancy,
                                     // [38:7] front_word, [70:39] back_word, [71] zero
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dir, n_dir;      // set: logical front is the high end
    logic             r_pend;
    t_status          r_status, n_status;
    logic             r_out_valid;
    logic [71:0]      r_out_data;

    t_phys_op         ph_op;
    t_word            key;
    logic             accept;
    logic             load_out;

    t_cell_ctl        cell_ctl  [DEPTH];
    t_word            cell_word [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic [DEPTH-1:0] mv;
    logic [DEPTH-1:0] shift_rm;
    logic             found;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_pend;
    assign key        = value_to_word(i_s_tdata);

    // matches inside the occupied range
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            mv[i] = cell_match[i] && (CNT_W'(i) < r_count);
        end
        found = |mv;
    end

    // cells at or above the removed entry take their upper neighbor
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            logic lo_any;
            logic hi_any;
            lo_any = 1'b0;
            hi_any = 1'b0;
            for (int j = 0; j < DEPTH; j++) begin
                if (j <= i) lo_any = lo_any | mv[j];
                if (j > i)  hi_any = hi_any | mv[j];
            end
            shift_rm[i] = r_dir ? (found && !hi_any) : lo_any;
        end
    end

    // map the logical action onto the physical row
    always_comb begin
        ph_op    = PH_NONE;
        n_status = ST_OK;
        case (t_action'(i_s_tuser))
            ACT_PUSH_FRONT: begin
                if (r_count == CNT_W'(DEPTH)) n_status = ST_FULL;
                else ph_op = r_dir ? PH_PUSH_HI : PH_PUSH_LO;
            end
            ACT_PUSH_BACK: begin
                if (r_count == CNT_W'(DEPTH)) n_status = ST_FULL;
                else ph_op = r_dir ? PH_PUSH_LO : PH_PUSH_HI;
            end
            ACT_POP_FRONT: begin
                if (r_count == '0) n_status = ST_EMPTY;
                else ph_op = r_dir ? PH_POP_HI : PH_POP_LO;
            end
            ACT_POP_BACK: begin
                if (r_count == '0) n_status = ST_EMPTY;
                else ph_op = r_dir ? PH_POP_LO : PH_POP_HI;
            end
            ACT_REMOVE: begin
                if (r_count == '0) n_status = ST_EMPTY;
                else if (!found) n_status = ST_NOTFOUND;
                else ph_op = PH_REMOVE;
            end
            ACT_REVERSE: begin
                if (r_count == '0) n_status = ST_EMPTY;
                else ph_op = PH_REVERSE;
            end
            default: begin
                ph_op    = PH_NONE;
                n_status = ST_OK;
            end
        endcase
        if (!accept) ph_op = PH_NONE;
    end

    always_comb begin
        n_count = r_count;
        n_dir   = r_dir;
        case (ph_op)
            PH_PUSH_LO, PH_PUSH_HI:           n_count = r_count + 1'b1;
            PH_POP_LO, PH_POP_HI, PH_REMOVE:  n_count = r_count - 1'b1;
            PH_REVERSE:                       n_dir   = !r_dir;
            default:                          n_count = r_count;
        endcase
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i].word = key;
            cell_ctl[i].op   = CELL_HOLD;
            case (ph_op)
                PH_PUSH_LO: begin
                    if (i == 0) cell_ctl[i].op = CELL_LOAD;
                    else if (CNT_W'(i) <= r_count) cell_ctl[i].op = CELL_FROM_LOWER;
                end
                PH_PUSH_HI: begin
                    if (CNT_W'(i) == r_count) cell_ctl[i].op = CELL_LOAD;
                end
                PH_POP_LO: begin
                    if (i < DEPTH - 1) cell_ctl[i].op = CELL_FROM_UPPER;
                end
                PH_REMOVE: begin
                    if (i < DEPTH - 1 && shift_rm[i]) cell_ctl[i].op = CELL_FROM_UPPER;
                end
                default: cell_ctl[i].op = CELL_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word lower_w;
        t_word upper_w;
        if (g == 0) begin : g_lo_end
            assign lower_w = cell_word[g];
        end else begin : g_lo
            assign lower_w = cell_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi_end
            assign upper_w = cell_word[g];
        end else begin : g_hi
            assign upper_w = cell_word[g+1];
        end
        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_lower (lower_w),
            .i_upper (upper_w),
            .o_word  (cell_word[g]),
            .o_match (cell_match[g])
        );
    end

    // result built from the updated row
    t_word            low_w, high_w;
    logic [CNT_W-1:0] last_c;
    logic [OUT_W-1:0] front_o, back_o;

    always_comb begin
        last_c = r_count - 1'b1;
        low_w  = cell_word[0];
        high_w = cell_word[last_c[IDX_W-1:0]];
        if (r_count == '0) begin
            front_o = '0;
            back_o  = '0;
        end else if (r_dir) begin
            front_o = word_to_out(high_w);
            back_o  = word_to_out(low_w);
        end else begin
            front_o = word_to_out(low_w);
            back_o  = word_to_out(high_w);
        end
    end

    assign load_out = r_pend && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dir       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_dir   <= n_dir;
            if (accept) begin
                r_pend <= 1'b1;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
        if (load_out) begin
            r_out_data <= {1'b0, back_o, front_o, count_to_occ(r_count), r_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> src/bdq_cell.sv
// One storage cell of the deque row: holds a word, loads or takes a neighbor.
`timescale 1ns / 1ps

module bdq_cell import bdq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_word     i_lower,
    input  t_word     i_upper,
    output t_word     o_word,
    output logic      o_match
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        case (i_ctl.op)
            CELL_LOAD:       n_word = i_ctl.word;
            CELL_FROM_LOWER: n_word = i_lower;
            CELL_FROM_UPPER: n_word = i_upper;
            default:         n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_match = (r_word == i_ctl.word);

endmodule

>>> tb/bounded_deque_with_value_remove_tb.sv
// Self-checking testbench for the bounded deque with value removal.
`timescale 1ns / 1ps

module bounded_deque_with_value_remove_tb;
    import bdq_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 1420;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct {
        logic [ACTION_W-1:0] action_code;
        logic [VALUE_W-1:0]  value;
        bit                  hold_for_drain;   // wait until all results are back
    } t_request;

    typedef struct {
        t_status          status;
        logic [OCC_W-1:0] occupancy;
        logic [OUT_W-1:0] front_word;
        logic [OUT_W-1:0] back_word;
    } t_deque_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] value
    logic [2:0]  s_tuser = '0;   // [2:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // [1:0] status, [6:2] occupancy,
                                 // [38:7] front_word, [70:39] back_word

    t_request      pending_requests[$];
    t_deque_result expected_results[$];
    t_word         held_words[$];     // predicted contents, front first
    t_request      current_request;
    t_word         key_pool[8];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_gap       = 0;
    int  recv_stall     = 0;
    bit  send_burst     = 1'b0;
    bit  recv_burst     = 1'b0;
    bit  send_busy      = 1'b0;
    bit  recv_ready;

    bounded_deque_with_value_remove dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Predicts the deque after one request and queues the result it must report.
    task automatic apply_request(input t_request rq);
        t_deque_result res;
        t_word         w;
        t_word         tmp;
        int            lo;
        int            hi;
        int            idx;
        bit            found;
        w     = value_to_word(rq.value);
        res.status = ST_OK;
        found = 1'b0;
        case (rq.action_code)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (held_words.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (rq.action_code == ACT_PUSH_FRONT) begin
                    held_words.push_front(w);
                end else begin
                    held_words.push_back(w);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE, ACT_REVERSE: begin
                if (held_words.size() == 0) begin
                    res.status = ST_EMPTY;
                end else if (rq.action_code == ACT_POP_FRONT) begin
                    void'(held_words.pop_front());
                end else if (rq.action_code == ACT_POP_BACK) begin
                    void'(held_words.pop_back());
                end else if (rq.action_code == ACT_REMOVE) begin
                    // only the match nearest the front goes
                    for (idx = 0; idx < held_words.size() && !found; idx++) begin
                        if (held_words[idx] == w) begin
                            held_words.delete(idx);
                            found = 1'b1;
                        end
                    end
                    if (!found) res.status = ST_NOTFOUND;
                end else begin
                    lo = 0;
                    hi = held_words.size() - 1;
                    while (lo < hi) begin
                        tmp            = held_words[lo];
                        held_words[lo] = held_words[hi];
                        held_words[hi] = tmp;
                        lo++;
                        hi--;
                    end
                end
            end
            default: ;   // spare codes leave the deque alone
        endcase
        res.occupancy = OCC_W'(held_words.size());
        if (held_words.size() == 0) begin
            res.front_word = '0;
            res.back_word  = '0;
        end else begin
            res.front_word = held_words[0];
            res.back_word  = held_words[held_words.size() - 1];
        end
        expected_results.push_back(res);
    endtask

    task automatic queue_request(input logic [ACTION_W-1:0] code,
                                 input logic [VALUE_W-1:0] value, input bit hold);
        t_request rq;
        rq.action_code    = code;
        rq.value          = value;
        rq.hold_for_drain = hold;
        pending_requests.push_back(rq);
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] exp_val,
                               input logic [OUT_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            send_busy = 1'b0;
            send_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(current_request);
                send_busy = 1'b0;
                if ($urandom_range(0, 31) == 0) send_burst = ~send_burst;
                send_gap = draw_wait(send_burst);
            end
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() > 0) begin
                    if (!pending_requests[0].hold_for_drain || expected_results.size() == 0)
                    begin
                        current_request = pending_requests.pop_front();
                        send_busy = 1'b1;
                    end
                end
            end
            s_tvalid <= send_busy;
            s_tdata  <= current_request.value;
            s_tuser  <= current_request.action_code;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    t_deque_result exp_res;
                    exp_res = expected_results.pop_front();
                    check_field("status", OUT_W'(exp_res.status), OUT_W'(m_tdata[1:0]));
                    check_field("occupancy", OUT_W'(exp_res.occupancy),
                                OUT_W'(m_tdata[6:2]));
                    check_field("front_word", exp_res.front_word, m_tdata[38:7]);
                    check_field("back_word", exp_res.back_word, m_tdata[70:39]);
                end
                if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
                recv_stall = draw_wait(recv_burst);
            end
            recv_ready = (recv_stall == 0);
            if (recv_stall > 0) recv_stall--;
            m_tready <= recv_ready;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int          n;
        int          mood;
        int          push_pct;
        int          r;
        logic [2:0]  code;
        logic [31:0] value;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < 8; n++) key_pool[n] = $urandom;

        // empty deque, spare code, single entry, head removal
        queue_request(ACT_POP_FRONT, 32'h0, 1'b0);
        queue_request(ACT_POP_BACK, 32'h0, 1'b0);
        queue_request(ACT_REMOVE, 32'h0, 1'b0);
        queue_request(ACT_REVERSE, 32'h0, 1'b0);
        queue_request(ACT_SPARE_LO, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_REVERSE, 32'h0, 1'b0);
        queue_request(ACT_PUSH_BACK, 32'h0, 1'b0);
        queue_request(ACT_REMOVE, 32'h1234_5678, 1'b0);
        queue_request(ACT_REMOVE, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_POP_BACK, 32'h0, 1'b0);
        // fill with repeated words, push into the full deque, then spare code, remove, reverse and pops
        for (n = 0; n < DEPTH; n++) queue_request(ACT_PUSH_BACK, n % 3, 1'b0);
        queue_request(ACT_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0);
        queue_request(ACT_PUSH_BACK, 32'h5A5A_5A5A, 1'b0);
        queue_request(ACT_SPARE_HI, 32'h0, 1'b0);
        queue_request(ACT_REMOVE, 32'h1, 1'b0);
        queue_request(ACT_REVERSE, 32'h0, 1'b0);
        queue_request(ACT_POP_FRONT, 32'h0, 1'b0);
        queue_request(ACT_POP_BACK, 32'h0, 1'b0);

        // random part in phases that lean toward filling, draining or neither
        mood = 0;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 50 == 0) mood = $urandom_range(0, 2);
            push_pct = (mood == 0) ? 70 : (mood == 1) ? 20 : 45;
            if ($urandom_range(0, 99) < push_pct) begin
                code = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35)      code = ACT_POP_FRONT;
                else if (r < 70) code = ACT_POP_BACK;
                else if (r < 88) code = ACT_REMOVE;
                else if (r < 96) code = ACT_REVERSE;
                else             code = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            end
            // a small pool of keys makes duplicates and remove hits common
            if ($urandom_range(0, 9) < 6) value = key_pool[$urandom_range(0, 7)];
            else                          value = $urandom;
            queue_request(code, value, (n % 300) == 150);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> bounded_deque_with_value_remove.f
src/bdq_pkg.sv
src/bdq_cell.sv
src/bounded_deque_with_value_remove.sv
tb/bounded_deque_with_value_remove_tb.sv
